@@ sv/haar_dwt_single_level_q31_assert.svh @@
// Assertion macros shared by the Haar transform modules.
`ifndef HAAR_DWT_SINGLE_LEVEL_Q31_ASSERT_SVH
`define HAAR_DWT_SINGLE_LEVEL_Q31_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HDWT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdwt assertion failed");
`define HDWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdwt assertion failed");
`else
`define HDWT_ASSERT_SAME(label, clk, rst, ante, cons)
`define HDWT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/hdwt_pkg.sv @@
`timescale 1ns / 1ps

package hdwt_pkg;

   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_EXTENSION = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMALIZED     = 1'd1;

   // sqrt(1/2) in Q31.
   localparam logic signed [31:0] INV_SQRT2_Q31 = 32'sh5a82799a;
   localparam int unsigned        HAAR_SHIFT    = 31;

   typedef enum logic [2:0] {
      EDGE_ZERO          = 3'd0,
      EDGE_CONSTANT      = 3'd1,
      EDGE_SYMMETRIC     = 3'd2,
      EDGE_REFLECT       = 3'd3,
      EDGE_ANTISYMMETRIC = 3'd4,
      EDGE_ANTIREFLECT   = 3'd5,
      EDGE_PERIODIC      = 3'd6
   } edge_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last_sample;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] approx;
      logic signed [31:0] detail;
      logic               last_result;
   } rsp_beat_type;

   typedef struct packed {
      logic valid;
      logic last;
   } sum_ctl_type;

endpackage

@@ sv/hdwt_chan_if.sv @@
`timescale 1ns / 1ps

interface hdwt_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/hdwt_pair.sv @@
`timescale 1ns / 1ps
`include "haar_dwt_single_level_q31_assert.svh"

module hdwt_pair #(
   parameter int unsigned SAMPLE_BITS = 32,
   parameter int unsigned SUM_BITS    = SAMPLE_BITS + 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hdwt_pkg::edge_type         edge_mode,
   hdwt_chan_if.sink                  req_chan,
   input  logic                       sum_ready,
   output hdwt_pkg::sum_ctl_type      sum_ctl,
   output logic signed [SUM_BITS-1:0] sum_lo,
   output logic signed [SUM_BITS-1:0] sum_hi
);

   logic                          phase_ff, phase_in;
   logic signed [SAMPLE_BITS-1:0] held_ff, held_in;
   logic signed [SAMPLE_BITS-1:0] earlier_ff, earlier_in;
   logic                          sum_valid_ff, sum_valid_in;
   logic                          sum_last_ff, sum_last_in;
   logic signed [SUM_BITS-1:0]    sum_lo_ff, sum_lo_in;
   logic signed [SUM_BITS-1:0]    sum_hi_ff, sum_hi_in;

   logic                          accept;
   logic                          last;
   logic signed [SAMPLE_BITS-1:0] x_raw;
   logic signed [SUM_BITS-1:0]    xw, aw, pw;
   logic signed [SUM_BITS-1:0]    tail_lo, tail_hi;

   assign req_chan.ready = !sum_valid_ff || sum_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign last           = req_chan.payload.last_sample;
   assign x_raw          = req_chan.payload.sample[SAMPLE_BITS-1:0];
   assign xw             = SUM_BITS'(x_raw);
   assign aw             = SUM_BITS'(held_ff);
   assign pw             = SUM_BITS'(earlier_ff);

   always_comb begin
      case (edge_mode)
         hdwt_pkg::EDGE_CONSTANT, hdwt_pkg::EDGE_SYMMETRIC: begin
            tail_lo = xw + xw;
            tail_hi = '0;
         end
         hdwt_pkg::EDGE_REFLECT: begin
            tail_lo = xw + pw;
            tail_hi = xw - pw;
         end
         hdwt_pkg::EDGE_ANTISYMMETRIC: begin
            tail_lo = '0;
            tail_hi = xw + xw;
         end
         hdwt_pkg::EDGE_ANTIREFLECT: begin
            tail_lo = xw + xw + xw - pw;
            tail_hi = pw - xw;
         end
         default: begin
            tail_lo = xw;
            tail_hi = xw;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      held_in      = held_ff;
      earlier_in   = earlier_ff;
      sum_valid_in = sum_valid_ff && !sum_ready;
      sum_last_in  = sum_last_ff;
      sum_lo_in    = sum_lo_ff;
      sum_hi_in    = sum_hi_ff;
      if (accept) begin
         sum_valid_in = phase_ff || last;
         sum_last_in  = last;
         if (phase_ff) begin
            sum_lo_in  = aw + xw;
            sum_hi_in  = aw - xw;
            earlier_in = x_raw;
            phase_in   = 1'b0;
         end else if (!last) begin
            held_in  = x_raw;
            phase_in = 1'b1;
         end else begin
            sum_lo_in = tail_lo;
            sum_hi_in = tail_hi;
         end
         if (last) begin
            held_in    = '0;
            earlier_in = '0;
            phase_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         held_ff      <= '0;
         earlier_ff   <= '0;
         sum_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         earlier_ff   <= earlier_in;
         sum_valid_ff <= sum_valid_in;
      end
      sum_last_ff <= sum_last_in;
      sum_lo_ff   <= sum_lo_in;
      sum_hi_ff   <= sum_hi_in;
   end

   assign sum_ctl.valid = sum_valid_ff;
   assign sum_ctl.last  = sum_last_ff;
   assign sum_lo        = sum_lo_ff;
   assign sum_hi        = sum_hi_ff;

   // A signal always ends with the pairing and both stored samples cleared.
   `HDWT_ASSERT_NEXT(a_last_clears, clock, reset, accept && last,
      !phase_ff && earlier_ff == '0 && held_ff == '0)
   // The first sample of a pair gives no sum and leaves the pair half full.
   `HDWT_ASSERT_NEXT(a_first_no_sum, clock, reset, accept && !phase_ff && !last,
      phase_ff && !sum_valid_ff)

endmodule

@@ sv/hdwt_scale.sv @@
`timescale 1ns / 1ps
`include "haar_dwt_single_level_q31_assert.svh"

module hdwt_scale #(
   parameter int unsigned SUM_BITS = 35
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       normalized,
   input  hdwt_pkg::sum_ctl_type      sum_ctl,
   input  logic signed [SUM_BITS-1:0] sum_lo,
   input  logic signed [SUM_BITS-1:0] sum_hi,
   output logic                       sum_ready,
   hdwt_chan_if.source                rsp_chan
);

   localparam int unsigned PROD_BITS = SUM_BITS + 32;
   localparam int unsigned EXT_BITS  = hdwt_pkg::HAAR_SHIFT + 32;

   logic                   out_valid_ff, out_valid_in;
   hdwt_pkg::rsp_beat_type out_ff, out_in;
   logic                   take;

   function automatic logic signed [31:0] scale_sum(input logic signed [SUM_BITS-1:0] s,
                                                     input logic norm);
      logic signed [PROD_BITS-1:0] prod;
      logic signed [EXT_BITS-1:0]  ext;
      prod = s * hdwt_pkg::INV_SQRT2_Q31;
      ext  = EXT_BITS'(prod);
      if (norm) begin
         return ext[EXT_BITS-1:hdwt_pkg::HAAR_SHIFT];
      end
      return 32'(s);
   endfunction

   assign sum_ready = !out_valid_ff || rsp_chan.ready;
   assign take      = sum_ctl.valid && sum_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      if (take) begin
         out_valid_in       = 1'b1;
         out_in.approx      = scale_sum(sum_lo, normalized);
         out_in.detail      = scale_sum(sum_hi, normalized);
         out_in.last_result = sum_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   // An empty result register never holds back the sum stage.
   `HDWT_ASSERT_SAME(a_empty_ready, clock, reset, !out_valid_ff, sum_ready)
   // A sum that is taken shows up as a result in the next cycle.
   `HDWT_ASSERT_NEXT(a_take_shows, clock, reset, take, out_valid_ff)

endmodule

@@ sv/haar_dwt_single_level_q31.sv @@
`timescale 1ns / 1ps

// Single-level Haar wavelet transform on a stream of signed Q31 samples. Samples are paired in
// arrival order and each pair (a, b) yields approx = c*(a+b) and detail = c*(a-b), with c equal
// to sqrt(1/2) in Q31 when normalised and 1 otherwise; results wrap to 32 bits. A signal of odd
// length ends with one extra beat formed from the lone final sample, the sample before it and
// the edge extension mode. One sample beat is taken in every clock cycle unless the output
// stalls. The first stage pairs the samples and registers the sums, the second scales them by c
// into the result register; back-pressure can hold a result in either register. Configuration
// is to be written only while no signal is in flight.

module haar_dwt_single_level_q31 #(
   parameter int unsigned SAMPLE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   hdwt_chan_if.sink                             req_chan,
   hdwt_chan_if.source                           rsp_chan,
   input  logic                                  csr_we,
   input  logic [hdwt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [hdwt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int unsigned SUM_BITS = SAMPLE_BITS + 3;

   hdwt_pkg::edge_type         edge_ff, edge_in;
   logic                       norm_ff, norm_in;
   hdwt_pkg::sum_ctl_type      sum_ctl;
   logic signed [SUM_BITS-1:0] sum_lo;
   logic signed [SUM_BITS-1:0] sum_hi;
   logic                       sum_ready;

   always_comb begin
      edge_in = edge_ff;
      norm_in = norm_ff;
      if (csr_we) begin
         unique case (csr_index)
            hdwt_pkg::CSR_EDGE_EXTENSION: begin
               edge_in = hdwt_pkg::edge_type'(csr_wdata);
            end
            hdwt_pkg::CSR_NORMALIZED: begin
               norm_in = csr_wdata[0];
            end
            default: begin
               edge_in = edge_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= hdwt_pkg::EDGE_ZERO;
         norm_ff <= 1'b1;
      end else begin
         edge_ff <= edge_in;
         norm_ff <= norm_in;
      end
   end

   hdwt_pair #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_pair (
      .clock     (clock),
      .reset     (reset),
      .edge_mode (edge_ff),
      .req_chan  (req_chan),
      .sum_ready (sum_ready),
      .sum_ctl   (sum_ctl),
      .sum_lo    (sum_lo),
      .sum_hi    (sum_hi)
   );

   hdwt_scale #(
      .SUM_BITS (SUM_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .normalized (norm_ff),
      .sum_ctl    (sum_ctl),
      .sum_lo     (sum_lo),
      .sum_hi     (sum_hi),
      .sum_ready  (sum_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule
